// File: sv/ust_pkg.sv
`default_nettype none
package ust_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W = 32;
   localparam int MODE_W = 2;
   localparam int ENTRY_COUNT_W = 7;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [ENTRY_COUNT_W-1:0] entry_count_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [IDX_W-1:0] index_type;

   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_REMOVE = 2'd1;
   localparam mode_type MODE_QUERY = 2'd2;

endpackage
`default_nettype wire

// File: sv/unordered_set_table.sv
// Set of up to CAPACITY distinct signed 32-bit values, packed in a table in no order.
// Request channel (req_valid, req_stall, req_mode, req_key_value): one beat per
// operation, insert, remove or membership query.
// Response channel (rsp_valid, rsp_stall, rsp_succeeded, rsp_full_rejected,
// rsp_entry_count): exactly one beat per request, in request order.
// An operation scans the stored entries one per cycle through the single read port
// of the value memory, stopping at the first match. The scan ends after the last
// entry when the value is missing, earlier when it is found, and a remove that moves
// the last entry into the freed slot then passes through ST_FETCH_LAST and ST_MOVE.
// The block works on one request at a time: req_stall is high from the cycle after
// acceptance until the response is loaded into the output register.
// A response waits in the output register while rsp_stall is high; the next request
// is accepted meanwhile, and its response is held back until the register frees.
// Synchronous reset empties the set and drops any pending response; the memory
// needs no clearing, since only slots that have been written are ever read.
`default_nettype none
module unordered_set_table (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire ust_pkg::mode_type        req_mode,
   input  wire ust_pkg::key_type         req_key_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_succeeded,
   output logic                          rsp_full_rejected,
   output ust_pkg::entry_count_type      rsp_entry_count
);
   import ust_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_FETCH_LAST = 3'd2;
   localparam logic [2:0] ST_MOVE = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   key_type mem [CAPACITY];

   logic [2:0] state_ff, state_in;
   count_type count_ff, count_in;
   count_type issue_ff, issue_in;
   count_type cmp_idx_ff, cmp_idx_in;
   logic cmp_valid_ff, cmp_valid_in;
   count_type slot_ff, slot_in;
   mode_type mode_ff, mode_in;
   key_type key_ff, key_in;
   logic ok_ff, ok_in;
   logic full_ff, full_in;
   key_type rd_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_succeeded_ff, rsp_succeeded_in;
   logic rsp_full_rejected_ff, rsp_full_rejected_in;
   entry_count_type rsp_entry_count_ff, rsp_entry_count_in;

   logic rd_en;
   index_type rd_addr;
   logic wr_en;
   index_type wr_addr;
   key_type wr_data;
   logic accept, hit, miss, load_rsp;
   count_type last_idx;

   assign accept = req_valid && !req_stall;
   assign last_idx = count_type'(count_ff - 1'b1);
   assign hit = cmp_valid_ff && (rd_data_ff == key_ff);
   assign miss = (count_ff == '0) || (cmp_valid_ff && !hit && (cmp_idx_ff == last_idx));
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      issue_in = issue_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      slot_in = slot_ff;
      mode_in = mode_ff;
      key_in = key_ff;
      ok_in = ok_ff;
      full_in = full_ff;
      rd_en = 1'b0;
      rd_addr = issue_ff[IDX_W-1:0];
      wr_en = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_data = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               key_in = req_key_value;
               issue_in = '0;
               ok_in = 1'b0;
               full_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit || miss) begin
               state_in = ST_DONE;
               unique case (mode_ff)
                  MODE_INSERT: begin
                     if (!hit) begin
                        if (count_ff >= count_type'(CAPACITY)) begin
                           full_in = 1'b1;
                        end else begin
                           wr_en = 1'b1;
                           count_in = count_type'(count_ff + 1'b1);
                           ok_in = 1'b1;
                        end
                     end
                  end
                  MODE_REMOVE: begin
                     if (hit) begin
                        ok_in = 1'b1;
                        count_in = last_idx;
                        slot_in = cmp_idx_ff;
                        if (cmp_idx_ff != last_idx) begin
                           state_in = ST_FETCH_LAST;
                        end
                     end
                  end
                  MODE_QUERY: begin
                     ok_in = hit;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end else begin
               rd_en = (issue_ff < count_ff);
               cmp_valid_in = rd_en;
               cmp_idx_in = issue_ff;
               if (rd_en) begin
                  issue_in = count_type'(issue_ff + 1'b1);
               end
            end
         end
         ST_FETCH_LAST: begin
            rd_en = 1'b1;
            rd_addr = count_ff[IDX_W-1:0];
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            wr_en = 1'b1;
            wr_addr = slot_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_succeeded_in = rsp_succeeded_ff;
      rsp_full_rejected_in = rsp_full_rejected_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_succeeded_in = ok_ff;
         rsp_full_rejected_in = full_ff;
         rsp_entry_count_in = entry_count_type'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      slot_ff <= slot_in;
      mode_ff <= mode_in;
      key_ff <= key_in;
      ok_ff <= ok_in;
      full_ff <= full_in;
      rsp_succeeded_ff <= rsp_succeeded_in;
      rsp_full_rejected_ff <= rsp_full_rejected_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_succeeded = rsp_succeeded_ff;
   assign rsp_full_rejected = rsp_full_rejected_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule
`default_nettype wire

// File: sv/ust_checker.sv
`default_nettype none
module ust_assertions (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_succeeded,
   input wire logic                     rsp_full_rejected,
   input wire ust_pkg::entry_count_type rsp_entry_count
);
   import ust_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_succeeded)
         && $stable(rsp_full_rejected) && $stable(rsp_entry_count))
      else $error("response beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in progress");

   a_full_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_rejected |-> !rsp_succeeded
         && (rsp_entry_count == entry_count_type'(CAPACITY)))
      else $error("full rejection with success or a count below capacity");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= entry_count_type'(CAPACITY)))
      else $error("entry count above capacity");

endmodule

bind unordered_set_table ust_assertions u_ust_assertions (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_succeeded     (rsp_succeeded),
   .rsp_full_rejected (rsp_full_rejected),
   .rsp_entry_count   (rsp_entry_count)
);
`default_nettype wire

// File: bench/ust_checker.sv
module ust_checker
   import ust_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_stall,
   input  wire mode_type        req_mode,
   input  wire key_type         req_key_value,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_stall,
   input  wire logic            rsp_succeeded,
   input  wire logic            rsp_full_rejected,
   input  wire entry_count_type rsp_entry_count,
   output int                   mismatch_count,
   output int                   awaited_count,
   output int                   refusal_count,
   output int                   peak_size
);

   typedef struct packed {
      logic            succeeded;
      logic            full_rejected;
      entry_count_type entry_count;
   } outcome_type;

   key_type     slot_values [CAPACITY];
   count_type   set_size;
   outcome_type awaited_outcomes [$];

   initial begin
      mismatch_count = 0;
      awaited_count = 0;
      refusal_count = 0;
      peak_size = 0;
      set_size = '0;
   end

   function automatic int find_slot(key_type key);
      for (int i = 0; i < int'(set_size); i++) begin
         if (slot_values[i] == key) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one operation to the shadow set and returns the response it should produce.
   function automatic outcome_type apply_operation(mode_type mode, key_type key);
      outcome_type outcome;
      int          slot;
      outcome = '0;
      slot = find_slot(key);
      case (mode)
         MODE_INSERT: begin
            if (slot < 0) begin
               if (int'(set_size) >= CAPACITY) begin
                  outcome.full_rejected = 1'b1;
               end else begin
                  slot_values[set_size] = key;
                  set_size = set_size + 1'b1;
                  outcome.succeeded = 1'b1;
               end
            end
         end
         MODE_REMOVE: begin
            if (slot >= 0) begin
               slot_values[slot] = slot_values[int'(set_size) - 1];
               set_size = set_size - 1'b1;
               outcome.succeeded = 1'b1;
            end
         end
         MODE_QUERY: begin
            outcome.succeeded = (slot >= 0);
         end
         default: begin
         end
      endcase
      outcome.entry_count = entry_count_type'(set_size);
      return outcome;
   endfunction

   task automatic check_field(string field, int wanted, int seen);
      if (wanted != seen) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, seen);
      end
   endtask

   always @(posedge clock) begin : monitor
      outcome_type wanted;
      if (reset) begin
         set_size = '0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%0t: response beat with nothing expected, actual %0d/%0d/%0d",
                        $time, rsp_succeeded, rsp_full_rejected, rsp_entry_count);
            end else begin
               wanted = awaited_outcomes.pop_front();
               check_field("succeeded", wanted.succeeded, rsp_succeeded);
               check_field("full_rejected", wanted.full_rejected, rsp_full_rejected);
               check_field("entry_count", wanted.entry_count, rsp_entry_count);
            end
         end
         if (req_valid && !req_stall) begin
            wanted = apply_operation(req_mode, req_key_value);
            awaited_outcomes.push_back(wanted);
            if (wanted.full_rejected) begin
               refusal_count++;
            end
            if (int'(set_size) > peak_size) begin
               peak_size = int'(set_size);
            end
         end
      end
      awaited_count = awaited_outcomes.size();
   end

endmodule

// File: bench/tb_top.sv
module tb_top;
   import ust_pkg::*;

   localparam mode_type MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1350;
   localparam int PHASE_ITEMS = 150;
   localparam int POOL_SIZE = 96;
   localparam int CYCLE_LIMIT = 800000;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   mode_type        req_mode;
   key_type         req_key_value;
   logic            rsp_valid;
   logic            rsp_stall;
   logic            rsp_succeeded;
   logic            rsp_full_rejected;
   entry_count_type rsp_entry_count;

   int      cycle_count = 0;
   int      mismatch_count;
   int      awaited_count;
   int      refusal_count;
   int      peak_size;
   int      mode_tally [4];
   key_type key_pool [POOL_SIZE];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   unordered_set_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_key_value     (req_key_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_succeeded     (rsp_succeeded),
      .rsp_full_rejected (rsp_full_rejected),
      .rsp_entry_count   (rsp_entry_count)
   );

   ust_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_key_value     (req_key_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_succeeded     (rsp_succeeded),
      .rsp_full_rejected (rsp_full_rejected),
      .rsp_entry_count   (rsp_entry_count),
      .mismatch_count    (mismatch_count),
      .awaited_count     (awaited_count),
      .refusal_count     (refusal_count),
      .peak_size         (peak_size)
   );

   task automatic issue_op(mode_type mode, key_type key);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_key_value <= key;
      mode_tally[mode]++;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      req_mode <= mode_type'($urandom_range(3));
      req_key_value <= key_type'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   function automatic key_type pick_key();
      if ($urandom_range(99) < 85) begin
         return key_pool[$urandom_range(POOL_SIZE - 1)];
      end
      return key_type'($urandom);
   endfunction

   function automatic mode_type pick_mode(bit growing);
      int roll;
      roll = $urandom_range(99);
      if (roll >= 97) begin
         return MODE_UNUSED;
      end else if (roll < (growing ? 72 : 15)) begin
         return MODE_INSERT;
      end else if (roll < (growing ? 84 : 75)) begin
         return MODE_REMOVE;
      end
      return MODE_QUERY;
   endfunction

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               cycle_count, awaited_count);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int span;
      int style;
      int segment;
      segment = 0;
      rsp_stall = 1'b0;
      repeat (10) @(negedge clock);
      forever begin
         segment++;
         if (segment % 25 == 6) begin
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
         end else begin
            style = $urandom_range(3);
            span = $urandom_range(20, 300);
            repeat (span) begin
               case (style)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(1) == 1);
                  2: rsp_stall <= ($urandom_range(9) < 8);
                  default: rsp_stall <= ~rsp_stall;
               endcase
               @(negedge clock);
            end
         end
      end
   end

   initial begin
      int burst_left;
      int gap;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_INSERT;
      req_key_value = '0;
      burst_left = 0;
      foreach (mode_tally[i]) begin
         mode_tally[i] = 0;
      end
      foreach (key_pool[i]) begin
         key_pool[i] = key_type'($urandom);
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      key_pool[4] = 32'h0000_0001;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      issue_op(MODE_QUERY, 32'h0000_0000);
      issue_op(MODE_REMOVE, 32'h0000_0005);
      issue_op(MODE_INSERT, 32'h8000_0000);
      issue_op(MODE_INSERT, 32'h7FFF_FFFF);
      issue_op(MODE_INSERT, 32'h0000_0000);
      issue_op(MODE_INSERT, 32'hFFFF_FFFF);
      issue_op(MODE_INSERT, 32'h8000_0000);
      issue_op(MODE_QUERY, 32'h8000_0000);
      issue_op(MODE_QUERY, 32'hFFFF_FFFF);
      issue_op(MODE_QUERY, 32'h0000_0001);
      issue_op(MODE_UNUSED, 32'hFFFF_FFFF);
      issue_op(MODE_REMOVE, 32'hFFFF_FFFF);
      issue_op(MODE_REMOVE, 32'h8000_0000);
      issue_op(MODE_QUERY, 32'h7FFF_FFFF);
      issue_op(MODE_QUERY, 32'h0000_0000);
      issue_op(MODE_REMOVE, 32'h7FFF_FFFF);
      issue_op(MODE_REMOVE, 32'h7FFF_FFFF);
      issue_op(MODE_INSERT, 32'h5555_5555);
      issue_op(MODE_INSERT, 32'hAAAA_AAAA);
      issue_op(MODE_REMOVE, 32'h5555_5555);
      issue_op(MODE_QUERY, 32'hAAAA_AAAA);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
            pause_sender(gap);
            burst_left = $urandom_range(1, 24);
         end
         issue_op(pick_mode((i / PHASE_ITEMS) % 2 == 0), pick_key());
         burst_left--;
      end
      req_valid <= 1'b0;

      wait (awaited_count == 0);
      repeat (2 * CAPACITY + 8) @(posedge clock);

      $display("Covered %0d inserts, %0d removes, %0d queries and %0d unused-mode beats.",
               mode_tally[MODE_INSERT], mode_tally[MODE_REMOVE], mode_tally[MODE_QUERY],
               mode_tally[MODE_UNUSED]);
      $display("Inserts refused on a full table: %0d; peak occupancy %0d of %0d.",
               refusal_count, peak_size, CAPACITY);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
sv/ust_pkg.sv
sv/unordered_set_table.sv
sv/ust_checker.sv
bench/ust_checker.sv
bench/tb_top.sv
